// ----- design/gf2pa_pkg.sv -----
`timescale 1ns / 1ps
// package for the gf2 polynomial alu: operation codes, word widths and defaults
// no dependencies

package gf2pa_pkg;

  localparam int OP_W   = 3;
  localparam int OPND_W = 32;
  localparam int MOD_W  = 33;
  localparam int RES_W  = 63;

  localparam int POLY_WIDTH_DEF = 32;

  localparam logic [MOD_W-1:0] MOD_RESET = 33'd19;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 3'd0,
    OP_MUL = 3'd1,
    OP_QUO = 3'd2,
    OP_REM = 3'd3,
    OP_SUB = 3'd4
  } op_t;

endpackage

// ----- design/gf2_polynomial_alu.sv -----
`timescale 1ns / 1ps
// gf2 polynomial alu: add, carry-less multiply, long division, substitution mod field
// path from accept to out_valid: add, unused codes and error words go straight to write-back,
//   multiply, divide and substitute first iterate, one shift-reduce step per cycle
// throughput: one word at a time; input stalls until the result is in the output register
// reset: synchronous active-low rst_n, sequencer idle, output empty, modulus set to 19
// depends on gf2pa_pkg

module gf2_polynomial_alu
  import gf2pa_pkg::*;
#(
  parameter int POLY_WIDTH = POLY_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [MOD_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_op,
  input  logic [OPND_W-1:0] in_a_operand,
  input  logic [OPND_W-1:0] in_b_operand,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [RES_W-1:0]  out_result_value,
  output logic              out_error_flag
);

  localparam int CNT_W = $clog2(POLY_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(POLY_WIDTH - 1);
  localparam logic [OPND_W-1:0] OPND_MASK = OPND_W'((64'd1 << POLY_WIDTH) - 64'd1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_SUB,
    S_WB
  } state_t;

  state_t              state_r;
  logic [OP_W-1:0]     op_r;
  logic [OPND_W-1:0]   a_r;
  logic [OPND_W-1:0]   b_r;
  logic [OPND_W-1:0]   bs_r;
  logic [RES_W-1:0]    acc_r;
  logic [MOD_W-1:0]    rem_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    icnt_r;
  logic [RES_W-1:0]    res_r;
  logic                err_r;
  logic [MOD_W-1:0]    mod_r;
  logic                out_valid_r;
  logic [RES_W-1:0]    out_res_r;
  logic                out_err_r;

  logic [OPND_W-1:0]   a_in;
  logic [OPND_W-1:0]   b_in;
  logic [MOD_W-1:0]    div_sh;
  logic [MOD_W-1:0]    div_x;
  logic [MOD_W-1:0]    div_rem;
  logic [MOD_W-1:0]    sub_p2;
  logic [MOD_W-1:0]    sub_px;
  logic [MOD_W-1:0]    sub_red;
  logic [OPND_W-1:0]   sub_p;
  logic [OPND_W-1:0]   sub_h;
  logic [RES_W-1:0]    mul_acc;
  logic [RES_W-1:0]    quo_acc;
  logic [MOD_W-1:0]    cmp_x;
  logic [MOD_W-1:0]    cmp_y;
  logic                cmp_lt;
  logic                a_top;
  logic                b_top;
  logic                mod_not_one;
  logic                out_free;

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_value = out_res_r;
  assign out_error_flag   = out_err_r;

  assign a_in        = in_a_operand & OPND_MASK;
  assign b_in        = in_b_operand & OPND_MASK;
  assign a_top       = a_r[POLY_WIDTH-1];
  assign b_top       = bs_r[POLY_WIDTH-1];
  assign mod_not_one = (mod_r != MOD_W'(1));
  assign out_free    = !out_valid_r || !out_stall;

  // shared shift-reduce datapath
  always_comb begin
    mul_acc = {acc_r[RES_W-2:0], 1'b0} ^ (b_top ? {31'b0, a_r} : '0);
    div_sh  = {rem_r[OPND_W-1:0], a_top};
    div_x   = div_sh ^ {1'b0, b_r};
    sub_p2  = {rem_r[OPND_W-1:0], 1'b0};
    sub_px  = sub_p2 ^ mod_r;
    if (state_r == S_DIV) begin
      cmp_x = div_x;
      cmp_y = div_sh;
    end else begin
      cmp_x = sub_px;
      cmp_y = sub_p2;
    end
    cmp_lt  = (cmp_x < cmp_y);
    div_rem = cmp_lt ? div_x : div_sh;
    quo_acc = {acc_r[RES_W-2:0], cmp_lt};
    sub_red = cmp_lt ? sub_px : sub_p2;
    sub_p   = sub_red[OPND_W-1:0] ^ (b_top ? acc_r[OPND_W-1:0] : '0);
    sub_h   = sub_p ^ {31'b0, a_top & mod_not_one};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mod_r       <= MOD_RESET;
    end else begin
      if (cfg_we) begin
        mod_r <= cfg_wdata;
      end
      if (out_valid_r && !out_stall && state_r != S_WB) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r   <= in_op;
            a_r    <= a_in;
            b_r    <= b_in;
            bs_r   <= b_in;
            acc_r  <= '0;
            rem_r  <= '0;
            cnt_r  <= CNT_LAST;
            icnt_r <= CNT_LAST;
            unique case (in_op) inside
              OP_ADD: begin
                res_r   <= {31'b0, a_in ^ b_in};
                err_r   <= 1'b0;
                state_r <= S_WB;
              end
              OP_MUL: begin
                res_r   <= '0;
                err_r   <= 1'b0;
                state_r <= S_MUL;
              end
              OP_QUO, OP_REM: begin
                res_r <= '0;
                if (b_in == '0) begin
                  err_r   <= 1'b1;
                  state_r <= S_WB;
                end else begin
                  err_r   <= 1'b0;
                  state_r <= S_DIV;
                end
              end
              OP_SUB: begin
                res_r <= '0;
                if (mod_r == '0) begin
                  err_r   <= 1'b1;
                  state_r <= S_WB;
                end else begin
                  err_r   <= 1'b0;
                  state_r <= S_SUB;
                end
              end
              default: begin
                res_r   <= '0;
                err_r   <= 1'b0;
                state_r <= S_WB;
              end
            endcase
          end
        end
        S_MUL: begin
          acc_r <= mul_acc;
          bs_r  <= bs_r << 1;
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            res_r   <= mul_acc;
            state_r <= S_WB;
          end
        end
        S_DIV: begin
          acc_r <= quo_acc;
          rem_r <= div_rem;
          a_r   <= a_r << 1;
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            res_r   <= (op_r == OP_QUO) ? quo_acc : {30'b0, div_rem};
            state_r <= S_WB;
          end
        end
        S_SUB: begin
          if (icnt_r != '0) begin
            icnt_r <= icnt_r - CNT_W'(1);
            rem_r  <= {1'b0, sub_p};
            bs_r   <= bs_r << 1;
          end else begin
            icnt_r <= CNT_LAST;
            acc_r  <= {31'b0, sub_h};
            rem_r  <= '0;
            bs_r   <= b_r;
            a_r    <= a_r << 1;
            cnt_r  <= cnt_r - CNT_W'(1);
            if (cnt_r == '0) begin
              res_r   <= {31'b0, sub_h};
              state_r <= S_WB;
            end
          end
        end
        S_WB: begin
          if (out_free) begin
            out_res_r   <= res_r;
            out_err_r   <= err_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_err_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_res_r == '0)
    else $error("error word carries a nonzero result");

  a_err_op: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WB && err_r |-> op_r == OP_QUO || op_r == OP_REM || op_r == OP_SUB)
    else $error("error flag raised by an op that cannot fail");

  a_load_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_WB))
    else $error("output register loaded outside write-back");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r[MOD_W-1] == 1'b0)
    else $error("division remainder exceeded divisor degree");

  a_sub_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SUB |-> rem_r[MOD_W-1] == 1'b0)
    else $error("substitution partial product not reduced");

endmodule
